FILE: rtl/gtc_pkg.sv
// Package for the glyph tag cache: sizes, slot record and request types.
// No dependencies.
package gtc_pkg;
	localparam int SLOT_COUNT = 256;
	localparam int AGE_WIDTH = 32;
	localparam int CP_W = 21;
	localparam int HT_W = 8;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	typedef struct packed {
		logic                 valid;
		logic [CP_W-1:0]      cp;
		logic [HT_W-1:0]      ht;
		logic [AGE_WIDTH-1:0] age;
		logic [IDX_W-1:0]     idx;
	} slot_t;

	typedef struct packed {
		logic                 load;
		logic                 write;
		logic [CP_W-1:0]      cp;
		logic [HT_W-1:0]      ht;
		logic [AGE_WIDTH-1:0] age;
		logic [IDX_W-1:0]     idx;
	} wr_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;
endpackage

FILE: rtl/glyph_tag_cache_lru.sv
// Top level of the glyph tag cache: ring of slot cells plus scan controller.
// Depends on gtc_pkg and gtc_cell.
// Fully associative 256-slot tag cache with timestamp LRU. The slots form a ring of cells
// that rotates one place per cycle while scanning; a request rotates the ring once while
// the head cell is compared for hit, first free slot and oldest age, then a second full
// rotation writes the chosen slot in whichever cell holds it. Result leaves through an
// output register. After reset a one-cycle load numbers the cells; all slots start invalid.
module glyph_tag_cache_lru import gtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata, // code_point[20:0], glyph_height[28:21]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata  // hit, slot_index[8:1], evicted_valid[9], evicted_code_point[30:10], evicted_height[38:31]
);
	state_t state_q, state_d;
	logic init_q, pass_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CP_W-1:0] cp_q;
	logic [HT_W-1:0] ht_q;
	logic [AGE_WIDTH-1:0] clk_q;
	logic hit_q, free_q;
	logic [IDX_W-1:0] hidx_q, fidx_q, oidx_q;
	logic [AGE_WIDTH-1:0] oage_q;
	logic [CP_W-1:0] ocp_q;
	logic [HT_W-1:0] oht_q;
	logic [39:0] out_q;
	logic shift, first;
	wr_t wr;
	slot_t ring [SLOT_COUNT];
	slot_t head;
	assign head = ring[SLOT_COUNT-1];

	genvar g;
	for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
		slot_t ini;
		always_comb begin
			ini = '0;
			ini.idx = IDX_W'(SLOT_COUNT - 1 - g);
		end
		gtc_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .wr(wr),
			.prev(ring[(g + SLOT_COUNT - 1) % SLOT_COUNT]), .init(ini), .cur(ring[g]));
	end

	assign shift = (state_q == ST_SCAN);
	assign first = (cnt_q == '0) && !pass_q;
	always_comb begin
		wr.load  = init_q;
		wr.write = shift && pass_q;
		wr.cp    = cp_q;
		wr.ht    = ht_q;
		wr.age   = clk_q + AGE_WIDTH'(1);
		wr.idx   = hit_q ? hidx_q : (free_q ? fidx_q : oidx_q);
	end

	assign s_tready = (state_q == ST_IDLE) && !init_q;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_d = ST_SCAN;
			ST_SCAN: if (pass_q && cnt_q == CNT_W'(SLOT_COUNT - 1)) state_d = ST_OUT;
			ST_OUT:  if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q  <= 1'b1;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
			clk_q   <= '0;
		end else begin
			init_q  <= 1'b0;
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q  <= '0;
				pass_q <= 1'b0;
			end else if (shift) begin
				if (cnt_q == CNT_W'(SLOT_COUNT - 1)) begin
					cnt_q  <= '0;
					pass_q <= 1'b1;
					if (pass_q) clk_q <= clk_q + AGE_WIDTH'(1);
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cp_q <= s_tdata[CP_W-1:0];
			ht_q <= s_tdata[CP_W+HT_W-1:CP_W];
		end
		if (shift && !pass_q) begin
			if (head.valid) begin
				if (head.cp == cp_q && head.ht == ht_q && (first || !hit_q)) begin
					hit_q <= 1'b1; hidx_q <= head.idx;
				end else if (first) hit_q <= 1'b0;
				if (first || head.age < oage_q ||
						(head.age == oage_q && head.idx < oidx_q)) begin
					oage_q <= head.age; oidx_q <= head.idx;
					ocp_q <= head.cp; oht_q <= head.ht;
				end
				if (first) free_q <= 1'b0;
			end else begin
				if (first || !free_q || head.idx < fidx_q) begin
					free_q <= 1'b1; fidx_q <= head.idx;
				end
				if (first) begin
					hit_q <= 1'b0;
					oage_q <= '1; oidx_q <= '1; ocp_q <= '0; oht_q <= '0;
				end
			end
		end
		if (state_q == ST_SCAN && state_d == ST_OUT) begin
			out_q <= {1'b0, (!hit_q && !free_q) ? {oht_q, ocp_q, 1'b1} : 30'b0,
				8'(wr.idx), hit_q};
		end
	end
endmodule

FILE: rtl/gtc_cell.sv
// One slot of the rotating tag ring; hands its record to the next cell every scan cycle.
// Depends on gtc_pkg.
module gtc_cell import gtc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  wr_t   wr,
	input  slot_t prev,
	input  slot_t init,
	output slot_t cur
);
	logic            valid_q;
	slot_t           rec_q;
	logic            sel;
	assign sel = wr.write && (prev.idx == wr.idx);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.load) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid || sel;
		end
	end
	always_ff @(posedge clk) begin
		if (wr.load) begin
			rec_q <= init;
		end else if (shift) begin
			if (sel) begin
				rec_q <= '{valid: prev.valid, cp: wr.cp, ht: wr.ht, age: wr.age,
					idx: prev.idx};
			end else begin
				rec_q <= prev;
			end
		end
	end
	always_comb begin
		cur = rec_q;
		cur.valid = valid_q;
	end
endmodule

FILE: sim/tb_top.sv
// Testbench for glyph_tag_cache_lru: random and directed tag lookups checked against
// an in-bench LRU cache predictor. Depends on gtc_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
	import gtc_pkg::*;

	typedef struct packed {
		logic [HT_W-1:0] ev_ht;
		logic [CP_W-1:0] ev_cp;
		logic            ev_valid;
		logic [7:0]      slot;
		logic            hit;
	} lookup_t;

	typedef struct packed {
		logic [HT_W-1:0] ht;
		logic [CP_W-1:0] cp;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	glyph_tag_cache_lru DUT (.*);

	always #4 clk = ~clk;

	// predictor state
	logic                 c_valid [SLOT_COUNT];
	logic [CP_W-1:0]      c_cp [SLOT_COUNT];
	logic [HT_W-1:0]      c_ht [SLOT_COUNT];
	logic [AGE_WIDTH-1:0] c_age [SLOT_COUNT];
	logic [AGE_WIDTH-1:0] use_clock;

	req_t    pending_reqs [$];
	lookup_t expected_lookups [$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      fails = 0;
	int      quiet_cycles = 0;
	bit      s_taken = 0;

	function automatic lookup_t predict_lookup(req_t r);
		lookup_t res;
		int hs, fs, old, s;
		hs = -1; fs = -1; old = 0;
		res = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (c_valid[i]) begin
				if (hs < 0 && c_cp[i] == r.cp && c_ht[i] == r.ht) hs = i;
				if (c_age[i] < c_age[old]) old = i;
			end else if (fs < 0) begin
				fs = i;
			end
		end
		use_clock = use_clock + 1'b1;
		if (hs >= 0) begin
			c_age[hs] = use_clock;
			res.hit = 1'b1;
			res.slot = hs[7:0];
			return res;
		end
		if (fs >= 0) begin
			s = fs;
		end else begin
			s = old;
			res.ev_valid = 1'b1;
			res.ev_cp = c_cp[s];
			res.ev_ht = c_ht[s];
		end
		c_valid[s] = 1'b1;
		c_cp[s] = r.cp;
		c_ht[s] = r.ht;
		c_age[s] = use_clock;
		res.slot = s[7:0];
		return res;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= {3'b0, pending_reqs.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		lookup_t got, exp_l;
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_lookups.push_back(predict_lookup(s_tdata[28:0]));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[38:0];
				if (expected_lookups.size() == 0) begin
					$display("%0t unexpected transfer: actual %h", $time, got);
					fails++;
				end else begin
					exp_l = expected_lookups.pop_front();
					if (got.hit !== exp_l.hit || got.slot !== exp_l.slot
						|| got.ev_valid !== exp_l.ev_valid || got.ev_cp !== exp_l.ev_cp
						|| got.ev_ht !== exp_l.ev_ht) begin
						$display("%0t mismatch: expected hit=%0d slot=%0d ev=%0d cp=%h ht=%h, actual hit=%0d slot=%0d ev=%0d cp=%h ht=%h",
							$time, exp_l.hit, exp_l.slot, exp_l.ev_valid, exp_l.ev_cp,
							exp_l.ev_ht, got.hit, got.slot, got.ev_valid, got.ev_cp, got.ev_ht);
						fails++;
					end
				end
			end
			if (quiet_cycles > 20000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic req_t rand_req(int pool);
		req_t r;
		if (pool > 0) begin
			r.cp = 21'($urandom_range(pool - 1)) ^ 21'h1A5A5;
			r.ht = 8'($urandom_range(3)) + 8'd12;
		end else begin
			r.cp = 21'($urandom);
			r.ht = 8'($urandom);
		end
		return r;
	endfunction

	task automatic add_req(logic [CP_W-1:0] cp, logic [HT_W-1:0] ht);
		pending_reqs.push_back('{ht: ht, cp: cp});
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (s_tvalid || expected_lookups.size() > 0) @(posedge clk);
	endtask

	initial begin
		int pct [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{36, 36}};
		for (int i = 0; i < SLOT_COUNT; i++) c_valid[i] = 1'b0;
		use_clock = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: extremes, hit, out-of-range code point, repeat hits
		add_req(21'h0, 8'h0);
		add_req(21'h1FFFFF, 8'hFF);
		add_req(21'h10FFFF, 8'h80);
		add_req(21'h0, 8'h0);
		add_req(21'h1FFFFF, 8'hFF);
		add_req(21'h0, 8'hFF);
		add_req(21'h1FFFFF, 8'h0);
		add_req(21'h110000, 8'h01);
		add_req(21'h0, 8'h0);
		for (int i = 0; i < 10; i++) add_req(21'(1 << (2 * i + 1)), 8'(1 << (i % 8)));
		add_req(21'h155555, 8'h55);
		add_req(21'h0AAAAA, 8'hAA);
		add_req(21'h155555, 8'h55);
		drain();

		// random phases: small tag pools give hits, wide pools force eviction
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pct[ph][0];
			recv_stall_pct = pct[ph][1];
			for (int i = 0; i < 450; i++) begin
				case ($urandom_range(3))
					0: pending_reqs.push_back(rand_req(0));
					1: pending_reqs.push_back(rand_req(64));
					default: pending_reqs.push_back(rand_req(400));
				endcase
			end
			drain();
		end
		repeat (600) @(posedge clk);
		if (fails == 0 && expected_lookups.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/gtc_pkg.sv
rtl/gtc_cell.sv
rtl/glyph_tag_cache_lru.sv
sim/tb_top.sv
